// File: hw/rtl/bmv_pkg.sv
// shared constants, types and helpers of the box match vote table
// no dependencies; bmv_argmax and box_match_vote_table refer to it by scoped names
`default_nettype none

package bmv_pkg;

  localparam int MaxBoxes = 16;
  localparam int VoteW    = 16;
  localparam int MaxLines = 16;
  localparam int IdxW     = $clog2(MaxBoxes);
  localparam int CntW     = $clog2(MaxBoxes + 1);
  localparam int RowW     = MaxBoxes * VoteW;
  localparam int CfgW     = 5;
  localparam int CfgIdxW  = 1;
  localparam int TotalW   = 16;
  localparam int BoxW     = 48;

  typedef enum logic [1:0] {
    OpLoadPrev = 2'd0,
    OpLoadCurr = 2'd1,
    OpMatch    = 2'd2,
    OpReport   = 2'd3
  } opcode_e;

  localparam logic [CfgIdxW-1:0] RegPrevCount = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegCurrCount = CfgIdxW'(1);

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] top;
    logic [11:0] width;
    logic [11:0] height;
  } box_t;

  // one contender of the best-cell search
  typedef struct packed {
    logic [VoteW-1:0] votes;
    logic [IdxW-1:0]  idx;
  } cand_t;

  // count register clipped to what the tables and the report can hold
  function automatic logic [CntW-1:0] used_count(input logic [CfgW-1:0] c);
    int lim;
    lim = (MaxBoxes < MaxLines) ? MaxBoxes : MaxLines;
    if (int'(c) > lim) return CntW'(lim);
    else return CntW'(c);
  endfunction

  function automatic logic [TotalW-1:0] sat_total(input logic [VoteW-1:0] v);
    logic [VoteW+TotalW-1:0] wide;
    wide = {{TotalW{1'b0}}, v};
    if (wide > (VoteW + TotalW)'({TotalW{1'b1}})) return '1;
    else return wide[TotalW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bmv_in_if.sv
// input channel of the box match vote table: valid/ready plus one command item
// depends on bmv_pkg for nothing but keeps the field widths of the item
`default_nettype none

interface bmv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  box_slot;
  logic [11:0] box_left;
  logic [11:0] box_top;
  logic [11:0] box_width;
  logic [11:0] box_height;
  logic [15:0] prev_kpt_x;
  logic [15:0] prev_kpt_y;
  logic [15:0] curr_kpt_x;
  logic [15:0] curr_kpt_y;

  modport source (
    output valid, opcode, box_slot, box_left, box_top, box_width, box_height,
           prev_kpt_x, prev_kpt_y, curr_kpt_x, curr_kpt_y,
    input  ready
  );
  modport sink (
    input  valid, opcode, box_slot, box_left, box_top, box_width, box_height,
           prev_kpt_x, prev_kpt_y, curr_kpt_x, curr_kpt_y,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/bmv_out_if.sv
// output channel of the box match vote table: valid/ready plus one report line
// no dependencies
`default_nettype none

interface bmv_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  prev_box;
  logic [3:0]  best_curr_box;
  logic        has_match;
  logic [15:0] vote_total;
  logic        last_line;

  modport source (
    output valid, prev_box, best_curr_box, has_match, vote_total, last_line,
    input  ready
  );
  modport sink (
    input  valid, prev_box, best_curr_box, has_match, vote_total, last_line,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/bmv_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module bmv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/bmv_argmax.sv
// two-stage reduction tree that finds the first cell with the most votes in a row
// depends on bmv_pkg for widths and the contender type
`default_nettype none

module bmv_argmax (
  input  wire logic                          clk_i,
  input  wire logic                          load_i,
  input  wire logic [bmv_pkg::RowW-1:0]      row_i,
  input  wire logic                          row_valid_i,
  input  wire logic [bmv_pkg::CntW-1:0]      nc_i,
  output      bmv_pkg::cand_t                best_o
);

  localparam int Pow2  = 1 << bmv_pkg::IdxW;
  localparam int Split = (bmv_pkg::IdxW + 1) / 2;
  localparam int N1    = Pow2 >> Split;

  bmv_pkg::cand_t lvl1 [Pow2];
  bmv_pkg::cand_t lvl2 [N1];
  bmv_pkg::cand_t stage_q [N1];

  // the higher index wins only when strictly larger, so ties keep the first
  function automatic bmv_pkg::cand_t pick(input bmv_pkg::cand_t a, input bmv_pkg::cand_t b);
    if (b.votes > a.votes) return b;
    else return a;
  endfunction

  always_comb begin
    for (int k = 0; k < Pow2; k++) begin
      lvl1[k].idx   = bmv_pkg::IdxW'(k);
      lvl1[k].votes = '0;
    end
    // cells outside the used range and unwritten rows count as zero
    for (int k = 0; k < bmv_pkg::MaxBoxes; k++) begin
      if (row_valid_i && (k < int'(nc_i))) begin
        lvl1[k].votes = row_i[k*bmv_pkg::VoteW +: bmv_pkg::VoteW];
      end
    end
    for (int l = 0; l < Split; l++) begin
      for (int k = 0; k < Pow2 / 2; k++) begin
        if (k < (Pow2 >> (l + 1))) begin
          lvl1[k] = pick(lvl1[2*k], lvl1[2*k+1]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int k = 0; k < N1; k++) begin
        stage_q[k] <= lvl1[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < N1; k++) begin
      lvl2[k] = stage_q[k];
    end
    for (int l = 0; l < bmv_pkg::IdxW - Split; l++) begin
      for (int k = 0; k < N1; k++) begin
        if (2*k + 1 < (N1 >> l)) begin
          lvl2[k] = pick(lvl2[2*k], lvl2[2*k+1]);
        end
      end
    end
    best_o = lvl2[0];
  end

endmodule

`default_nettype wire

// File: hw/rtl/box_match_vote_table.sv
// Box match vote table. Boxes of the previous and current frame are loaded by
// command items (opcode load prev / load curr) into two box memories; a match
// item carries one keypoint per frame and adds one vote, saturating, to every
// cell (prev box, curr box) whose boxes hold the two points; a report item
// sends one line per previous box in use naming the first current box with
// the most votes, then clears the vote table.
// Channels: in_if (command items) and out_if (report lines), valid/ready; the
// box counts are written over cfg_we_i/cfg_idx_i/cfg_wdata_i by the user only
// while idle; the block does not enforce it. A load writes its box memory as
// it is accepted. A match reads the current box memory once per box, then
// per previous box the previous box memory and a vote memory row, and writes
// the row back where that box holds its point (a row holds all cells of one
// prev box). A report line passes row read, first half of the best-cell tree,
// second half into the output register.
// The last report line may wait in the output register while the next item
// is accepted; if the receiver stalls earlier, the report holds its place.
// Reset clears the counts and the per-row valid flags, so the vote table
// reads as zero at once; the box memories are undefined until loaded.
`default_nettype none

module box_match_vote_table (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bmv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bmv_pkg::CfgW-1:0]     cfg_wdata_i,
  bmv_in_if.sink                            in_if,
  bmv_out_if.source                         out_if
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCscan = 3'd1;
  localparam logic [2:0] StPscan = 3'd2;
  localparam logic [2:0] StRrd   = 3'd3;
  localparam logic [2:0] StRtree = 3'd4;
  localparam logic [2:0] StRout  = 3'd5;

  logic [2:0]                     state_q;
  logic [bmv_pkg::CfgW-1:0]       prev_cnt_q, curr_cnt_q;
  logic [bmv_pkg::CntW-1:0]       np, nc;
  logic [bmv_pkg::CntW-1:0]       cnt_q;
  logic [bmv_pkg::CntW-1:0]       cnt_inc;
  logic                           pend_q;
  logic [bmv_pkg::IdxW-1:0]       pend_idx_q;
  logic                           rowv_q;
  logic [bmv_pkg::MaxBoxes-1:0]   cin_q;
  logic [bmv_pkg::MaxBoxes-1:0]   row_valid_q;
  logic [15:0]                    ppx_q, ppy_q, cpx_q, cpy_q;
  logic                           out_valid_q;
  logic                           out_load;
  logic                           in_fire;
  logic                           slot_ok;
  logic [bmv_pkg::BoxW-1:0]       box_wdata;
  logic [bmv_pkg::BoxW-1:0]       prev_rdata, curr_rdata;
  logic [bmv_pkg::RowW-1:0]       vote_rdata, vote_wdata;
  logic                           vote_we;
  logic                           prev_hit, curr_hit;
  bmv_pkg::cand_t                 best;
  logic [3:0]                     prev_box_q, best_curr_box_q;
  logic                           has_match_q, last_line_q;
  logic [15:0]                    vote_total_q;

  function automatic logic box_holds(input bmv_pkg::box_t b, input logic [15:0] px,
                                     input logic [15:0] py);
    logic [15:0] x0, y0;
    logic [16:0] x1, y1;
    x0 = {b.left, 4'b0};
    y0 = {b.top, 4'b0};
    x1 = {13'(b.left) + 13'(b.width), 4'b0};
    y1 = {13'(b.top) + 13'(b.height), 4'b0};
    return (px >= x0) && ({1'b0, px} < x1) && (py >= y0) && ({1'b0, py} < y1);
  endfunction

  assign np       = bmv_pkg::used_count(prev_cnt_q);
  assign nc       = bmv_pkg::used_count(curr_cnt_q);
  assign cnt_inc  = bmv_pkg::CntW'(cnt_q + 1'b1);
  assign in_if.ready = (state_q == StIdle);
  assign in_fire  = in_if.valid && in_if.ready;
  assign slot_ok  = int'(in_if.box_slot) < bmv_pkg::MaxBoxes;
  assign box_wdata = {in_if.box_left, in_if.box_top, in_if.box_width, in_if.box_height};

  assign prev_hit = box_holds(bmv_pkg::box_t'(prev_rdata), ppx_q, ppy_q);
  assign curr_hit = box_holds(bmv_pkg::box_t'(curr_rdata), cpx_q, cpy_q);
  assign vote_we  = (state_q == StPscan) && pend_q && prev_hit;
  assign out_load = (state_q == StRout) && (!out_valid_q || out_if.ready);

  // bump every cell of the row whose current box holds the current point
  always_comb begin
    logic [bmv_pkg::VoteW-1:0] cur_votes;
    for (int j = 0; j < bmv_pkg::MaxBoxes; j++) begin
      cur_votes = rowv_q ? vote_rdata[j*bmv_pkg::VoteW +: bmv_pkg::VoteW] : '0;
      if (cin_q[j] && (cur_votes != '1)) begin
        vote_wdata[j*bmv_pkg::VoteW +: bmv_pkg::VoteW] = bmv_pkg::VoteW'(cur_votes + 1'b1);
      end else begin
        vote_wdata[j*bmv_pkg::VoteW +: bmv_pkg::VoteW] = cur_votes;
      end
    end
  end

  bmv_ram #(.Width(bmv_pkg::BoxW), .Depth(bmv_pkg::MaxBoxes)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (in_if.opcode == bmv_pkg::OpLoadPrev) && slot_ok),
    .waddr_i (bmv_pkg::IdxW'(in_if.box_slot)),
    .wdata_i (box_wdata),
    .raddr_i (cnt_q[bmv_pkg::IdxW-1:0]),
    .rdata_o (prev_rdata)
  );

  bmv_ram #(.Width(bmv_pkg::BoxW), .Depth(bmv_pkg::MaxBoxes)) u_curr_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (in_if.opcode == bmv_pkg::OpLoadCurr) && slot_ok),
    .waddr_i (bmv_pkg::IdxW'(in_if.box_slot)),
    .wdata_i (box_wdata),
    .raddr_i (cnt_q[bmv_pkg::IdxW-1:0]),
    .rdata_o (curr_rdata)
  );

  bmv_ram #(.Width(bmv_pkg::RowW), .Depth(bmv_pkg::MaxBoxes)) u_vote_ram (
    .clk_i   (clk_i),
    .we_i    (vote_we),
    .waddr_i (pend_idx_q),
    .wdata_i (vote_wdata),
    .raddr_i (cnt_q[bmv_pkg::IdxW-1:0]),
    .rdata_o (vote_rdata)
  );

  bmv_argmax u_argmax (
    .clk_i       (clk_i),
    .load_i      (state_q == StRtree),
    .row_i       (vote_rdata),
    .row_valid_i (rowv_q),
    .nc_i        (nc),
    .best_o      (best)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prev_cnt_q  <= '0;
      curr_cnt_q  <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      rowv_q      <= 1'b0;
      cin_q       <= '0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bmv_pkg::RegPrevCount: prev_cnt_q <= cfg_wdata_i;
          bmv_pkg::RegCurrCount: curr_cnt_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            unique case (in_if.opcode)
              bmv_pkg::OpMatch: begin
                cnt_q   <= '0;
                pend_q  <= 1'b0;
                cin_q   <= '0;
                state_q <= StCscan;
              end
              bmv_pkg::OpReport: begin
                cnt_q <= '0;
                if (np == '0) begin
                  row_valid_q <= '0;
                end else begin
                  state_q <= StRrd;
                end
              end
              default: ;
            endcase
          end
        end
        StCscan: begin
          if (cnt_q < nc) begin
            cnt_q      <= cnt_inc;
            pend_q     <= 1'b1;
            pend_idx_q <= cnt_q[bmv_pkg::IdxW-1:0];
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q) begin
            cin_q[pend_idx_q] <= curr_hit;
          end
          if ((cnt_q == nc) && !pend_q) begin
            cnt_q   <= '0;
            state_q <= StPscan;
          end
        end
        StPscan: begin
          if (cnt_q < np) begin
            cnt_q      <= cnt_inc;
            pend_q     <= 1'b1;
            pend_idx_q <= cnt_q[bmv_pkg::IdxW-1:0];
            rowv_q     <= row_valid_q[cnt_q[bmv_pkg::IdxW-1:0]];
          end else begin
            pend_q <= 1'b0;
          end
          if (vote_we) begin
            row_valid_q[pend_idx_q] <= 1'b1;
          end
          if ((cnt_q == np) && !pend_q) begin
            state_q <= StIdle;
          end
        end
        StRrd: begin
          rowv_q  <= row_valid_q[cnt_q[bmv_pkg::IdxW-1:0]];
          state_q <= StRtree;
        end
        StRtree: begin
          state_q <= StRout;
        end
        StRout: begin
          if (out_load) begin
            cnt_q <= cnt_inc;
            if (cnt_inc == np) begin
              // report done: the whole vote table reads as zero again
              row_valid_q <= '0;
              state_q     <= StIdle;
            end else begin
              state_q <= StRrd;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_if.opcode == bmv_pkg::OpMatch)) begin
      ppx_q <= in_if.prev_kpt_x;
      ppy_q <= in_if.prev_kpt_y;
      cpx_q <= in_if.curr_kpt_x;
      cpy_q <= in_if.curr_kpt_y;
    end
    if (out_load) begin
      prev_box_q      <= 4'(cnt_q);
      best_curr_box_q <= 4'(best.idx);
      has_match_q     <= (nc != '0);
      vote_total_q    <= bmv_pkg::sat_total(best.votes);
      last_line_q     <= (cnt_inc == np);
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.prev_box      = prev_box_q;
  assign out_if.best_curr_box = best_curr_box_q;
  assign out_if.has_match     = has_match_q;
  assign out_if.vote_total    = vote_total_q;
  assign out_if.last_line     = last_line_q;

endmodule

`default_nettype wire

// File: dv/bmv_vote_check_pkg.sv
// item types and the vote scoreboard of the box match vote table bench
// depends on bmv_pkg for the opcode enum, the box layout and the table sizes
package bmv_vote_check_pkg;
  import bmv_pkg::*;

  typedef struct packed {
    opcode_e     op;
    logic [3:0]  slot;
    box_t        box;
    logic [15:0] prev_x;
    logic [15:0] prev_y;
    logic [15:0] curr_x;
    logic [15:0] curr_y;
  } command_t;

  typedef struct packed {
    logic [3:0]  prev_box;
    logic [3:0]  best_curr;
    logic        has_match;
    logic [15:0] total;
    logic        last_line;
  } report_line_t;

  class vote_board;
    box_t             prev_boxes[MaxBoxes];
    box_t             curr_boxes[MaxBoxes];
    logic [VoteW-1:0] votes[MaxBoxes][MaxBoxes];
    logic [CfgW-1:0]  prev_cnt;
    logic [CfgW-1:0]  curr_cnt;
    report_line_t     lines_due[$];
    int               errors;

    function new();
      prev_cnt = '0;
      curr_cnt = '0;
      errors   = 0;
      for (int i = 0; i < MaxBoxes; i++) begin
        prev_boxes[i] = '0;
        curr_boxes[i] = '0;
      end
      clear_votes();
    endfunction

    function void clear_votes();
      for (int i = 0; i < MaxBoxes; i++) begin
        for (int j = 0; j < MaxBoxes; j++) begin
          votes[i][j] = '0;
        end
      end
    endfunction

    function void set_count(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      if (idx == RegPrevCount) prev_cnt = val;
      else if (idx == RegCurrCount) curr_cnt = val;
    endfunction

    // counts above the table size behave as a full table
    function int unsigned in_use(logic [CfgW-1:0] c);
      int lim;
      lim = (MaxBoxes < MaxLines) ? MaxBoxes : MaxLines;
      return (int'(c) > lim) ? lim : int'(c);
    endfunction

    // pixel bounds against Q12.4 points, right and bottom edges exclusive
    function bit holds(box_t b, int unsigned px, int unsigned py);
      int unsigned x0, y0, x1, y1;
      x0 = 32'(b.left) * 32'd16;
      y0 = 32'(b.top) * 32'd16;
      x1 = (32'(b.left) + 32'(b.width)) * 32'd16;
      y1 = (32'(b.top) + 32'(b.height)) * 32'd16;
      return px >= x0 && px < x1 && py >= y0 && py < y1;
    endfunction

    function void note_command(command_t c);
      int unsigned      np, nc, best;
      logic [VoteW-1:0] most;
      bit               curr_hit[MaxBoxes];
      report_line_t     line;
      np = in_use(prev_cnt);
      nc = in_use(curr_cnt);
      case (c.op)
        OpLoadPrev: begin
          if (c.slot < MaxBoxes) prev_boxes[c.slot] = c.box;
        end
        OpLoadCurr: begin
          if (c.slot < MaxBoxes) curr_boxes[c.slot] = c.box;
        end
        OpMatch: begin
          for (int j = 0; j < nc; j++) curr_hit[j] = holds(curr_boxes[j], c.curr_x, c.curr_y);
          for (int i = 0; i < np; i++) begin
            if (holds(prev_boxes[i], c.prev_x, c.prev_y)) begin
              for (int j = 0; j < nc; j++) begin
                if (curr_hit[j] && votes[i][j] != '1) votes[i][j] = votes[i][j] + 1'b1;
              end
            end
          end
        end
        default: begin
          for (int i = 0; i < np; i++) begin
            best = 0;
            most = '0;
            for (int j = 0; j < nc; j++) begin
              if (j == 0 || votes[i][j] > most) begin
                most = votes[i][j];
                best = j;
              end
            end
            line.prev_box  = 4'(i);
            line.best_curr = 4'(best);
            line.has_match = (nc != 0);
            line.total     = (most > 'hFFFF) ? 16'hFFFF : 16'(most);
            line.last_line = (i + 1 == np);
            lines_due = {lines_due, line};
          end
          clear_votes();
        end
      endcase
    endfunction

    function int pending();
      return lines_due.size();
    endfunction

    task flag_mismatch(string what);
      errors++;
      if (errors <= 40) $display("tb_top: mismatch: %s", what);
    endtask

    task check_line(report_line_t got);
      report_line_t want;
      if (lines_due.size() == 0) begin
        flag_mismatch($sformatf("report line for prev box %0d with none due", got.prev_box));
        return;
      end
      want = lines_due.pop_front();
      if (got.prev_box !== want.prev_box)
        flag_mismatch($sformatf("prev_box got %0d want %0d", got.prev_box, want.prev_box));
      if (got.best_curr !== want.best_curr)
        flag_mismatch($sformatf("prev box %0d: best_curr_box got %0d want %0d",
                                want.prev_box, got.best_curr, want.best_curr));
      if (got.has_match !== want.has_match)
        flag_mismatch($sformatf("prev box %0d: has_match got %0b want %0b",
                                want.prev_box, got.has_match, want.has_match));
      if (got.total !== want.total)
        flag_mismatch($sformatf("prev box %0d: vote_total got %0d want %0d",
                                want.prev_box, got.total, want.total));
      if (got.last_line !== want.last_line)
        flag_mismatch($sformatf("prev box %0d: last_line got %0b want %0b",
                                want.prev_box, got.last_line, want.last_line));
    endtask
  endclass

endpackage

// File: dv/tb_top.sv
// top of the box match vote table bench: clock, reset, command driver and report sink
// depends on bmv_pkg, the two channel interfaces, bmv_vote_check_pkg and the block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmv_pkg::*;
  import bmv_vote_check_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int SettleCycles = 64;
  localparam int ItemTarget   = 440;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;
  logic               calm;
  int unsigned        cycles = 0;
  int                 sent;
  bit                 prev_written[MaxBoxes];
  bit                 curr_written[MaxBoxes];
  vote_board          sb;
  report_line_t       seen;

  bmv_in_if  in_ch ();
  bmv_out_if out_ch ();

  box_match_vote_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.prev_box  = out_ch.prev_box;
        seen.best_curr = out_ch.best_curr_box;
        seen.has_match = out_ch.has_match;
        seen.total     = out_ch.vote_total;
        seen.last_line = out_ch.last_line;
        sb.check_line(seen);
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  function automatic box_t mk_box(int l, int t, int w, int h);
    box_t b;
    b.left   = 12'(l);
    b.top    = 12'(t);
    b.width  = 12'(w);
    b.height = 12'(h);
    return b;
  endfunction

  // mostly small boxes near the origin so that they overlap and collect votes
  function automatic box_t rand_box();
    if ($urandom_range(99) < 12)
      return mk_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095));
    return mk_box($urandom_range(0, 50), $urandom_range(0, 50),
                  $urandom_range(0, 40), $urandom_range(0, 40));
  endfunction

  function automatic command_t rand_cmd();
    command_t cmd;
    cmd.op     = opcode_e'($urandom_range(0, 3));
    cmd.slot   = 4'($urandom);
    cmd.box    = mk_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095));
    cmd.prev_x = 16'($urandom);
    cmd.prev_y = 16'($urandom);
    cmd.curr_x = 16'($urandom);
    cmd.curr_y = 16'($urandom);
    return cmd;
  endfunction

  function automatic command_t report_cmd();
    command_t cmd;
    cmd    = rand_cmd();
    cmd.op = OpReport;
    return cmd;
  endfunction

  function automatic command_t match_at(int px, int py, int cx, int cy);
    command_t cmd;
    cmd        = rand_cmd();
    cmd.op     = OpMatch;
    cmd.prev_x = 16'(px);
    cmd.prev_y = 16'(py);
    cmd.curr_x = 16'(cx);
    cmd.curr_y = 16'(cy);
    return cmd;
  endfunction

  // {x, y}: usually inside the given box, otherwise anywhere
  function automatic logic [31:0] rand_point(input box_t b);
    int unsigned px, py;
    if (b.width == 0 || b.height == 0 || $urandom_range(99) < 20) begin
      if ($urandom_range(1) == 1) return $urandom;
      return {16'($urandom_range(0, 1200)), 16'($urandom_range(0, 1200))};
    end
    px = 32'(b.left) * 16 + $urandom_range(0, 32'(b.width) * 16 - 1);
    py = 32'(b.top) * 16 + $urandom_range(0, 32'(b.height) * 16 - 1);
    return {16'(px), 16'(py)};
  endfunction

  function automatic command_t rand_match(int unsigned np, int unsigned nc);
    logic [31:0] pp, cp;
    box_t        pb, cb;
    pb = (np > 0) ? sb.prev_boxes[$urandom_range(0, np - 1)] : rand_box();
    cb = (nc > 0) ? sb.curr_boxes[$urandom_range(0, nc - 1)] : rand_box();
    pp = rand_point(pb);
    cp = rand_point(cb);
    return match_at(pp[31:16], pp[15:0], cp[31:16], cp[15:0]);
  endfunction

  function automatic logic [CfgW-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CfgW'(1);
      2: return CfgW'(MaxBoxes);
      3: return '1;
      4: return CfgW'($urandom_range(MaxBoxes + 1, 30));
      default: return CfgW'($urandom_range(2, MaxBoxes - 1));
    endcase
  endfunction

  task automatic send(input command_t cmd);
    if (!calm && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= cmd.op;
    in_ch.box_slot   <= cmd.slot;
    in_ch.box_left   <= cmd.box.left;
    in_ch.box_top    <= cmd.box.top;
    in_ch.box_width  <= cmd.box.width;
    in_ch.box_height <= cmd.box.height;
    in_ch.prev_kpt_x <= cmd.prev_x;
    in_ch.prev_kpt_y <= cmd.prev_y;
    in_ch.curr_kpt_x <= cmd.curr_x;
    in_ch.curr_kpt_y <= cmd.curr_y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_command(cmd);
    if (cmd.op == OpLoadPrev) prev_written[cmd.slot] = 1'b1;
    if (cmd.op == OpLoadCurr) curr_written[cmd.slot] = 1'b1;
    sent++;
  endtask

  task automatic load_box(input opcode_e op, input int slot, input box_t b);
    command_t cmd;
    cmd      = rand_cmd();
    cmd.op   = op;
    cmd.slot = 4'(slot);
    cmd.box  = b;
    send(cmd);
  endtask

  // hold off until every report line is back, then let a match finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_counts(input logic [CfgW-1:0] p, input logic [CfgW-1:0] c);
    cfg_we    <= 1'b1;
    cfg_idx   <= RegPrevCount;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_idx   <= RegCurrCount;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_count(RegPrevCount, p);
    sb.set_count(RegCurrCount, c);
  endtask

  task automatic directed();
    // nothing in use: no lines, table still cleared
    send(report_cmd());
    drain();
    set_counts(CfgW'(3), CfgW'(3));
    load_box(OpLoadPrev, 0, mk_box(0, 0, 4095, 4095));
    load_box(OpLoadPrev, 1, mk_box(4095, 4095, 4095, 4095));
    load_box(OpLoadPrev, 2, mk_box(10, 20, 0, 5));
    load_box(OpLoadPrev, 15, mk_box(4095, 4095, 0, 0));
    load_box(OpLoadCurr, 0, mk_box(0, 0, 0, 0));
    load_box(OpLoadCurr, 1, mk_box(10, 10, 1, 1));
    load_box(OpLoadCurr, 2, mk_box(0, 0, 4095, 4095));
    load_box(OpLoadCurr, 15, mk_box(4095, 0, 4095, 0));
    // edges of the full-range boxes and the one-pixel box
    send(match_at(0, 0, 160, 160));
    send(match_at(65535, 65535, 175, 175));
    send(match_at(65520, 65520, 176, 160));
    send(match_at(65519, 0, 159, 160));
    send(match_at(160, 320, 65535, 65535));
    send(match_at(0, 0, 160, 160));
    send(report_cmd());
    // no current boxes in use
    drain();
    set_counts(CfgW'(3), '0);
    send(match_at(0, 0, 160, 160));
    send(report_cmd());
    // no previous boxes in use
    drain();
    set_counts('0, CfgW'(3));
    send(match_at(0, 0, 160, 160));
    send(report_cmd());
  endtask

  task automatic run_phase(input int idx);
    logic [CfgW-1:0] p, c;
    int unsigned     np, nc, n_match;
    case (idx)
      0: begin p = '1; c = CfgW'(MaxBoxes); end
      1: begin p = CfgW'(MaxBoxes); c = '1; end
      default: begin p = pick_count(); c = pick_count(); end
    endcase
    drain();
    calm <= (idx == 3);
    set_counts(p, c);
    np = sb.in_use(p);
    nc = sb.in_use(c);
    // every slot in use gets loaded before any match reads it
    for (int s = 0; s < np; s++)
      if (!prev_written[s] || $urandom_range(1) == 1) load_box(OpLoadPrev, s, rand_box());
    for (int s = 0; s < nc; s++)
      if (!curr_written[s] || $urandom_range(1) == 1) load_box(OpLoadCurr, s, rand_box());
    n_match = $urandom_range(1, 24);
    for (int k = 0; k < n_match; k++) begin
      if ($urandom_range(99) < 12) send(rand_cmd());
      else send(rand_match(np, nc));
    end
    send(report_cmd());
  endtask

  initial begin
    int phase;
    sb               = new();
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_wdata        = '0;
    calm             = 1'b0;
    sent             = 0;
    phase            = 0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = '0;
    in_ch.box_slot   = '0;
    in_ch.box_left   = '0;
    in_ch.box_top    = '0;
    in_ch.box_width  = '0;
    in_ch.box_height = '0;
    in_ch.prev_kpt_x = '0;
    in_ch.prev_kpt_y = '0;
    in_ch.curr_kpt_x = '0;
    in_ch.curr_kpt_y = '0;
    for (int s = 0; s < MaxBoxes; s++) begin
      prev_written[s] = 1'b0;
      curr_written[s] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    while (sent < ItemTarget) begin
      run_phase(phase);
      phase++;
    end
    drain();
    if (sb.errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
